FILE: rtl/core/mkd_pkg.sv
// Package for the keyer timing decoder: widths, register indexes and the
// state, configuration and result structs used by mkd_step and the top level.
// No dependencies.
package mkd_pkg;

  localparam int TIME_BITS    = 32;
  localparam int MAX_ELEMENTS = 8;
  localparam int IDX_W        = 3;
  localparam int CNT_W        = 4;
  localparam int PAT_W        = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [MAX_ELEMENTS-1:0] elem_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [PAT_W-1:0]        pat_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

  localparam cfg_idx_t CFG_DEBOUNCE_TIME  = 3'd0;
  localparam cfg_idx_t CFG_DOT_DASH_LIMIT = 3'd1;
  localparam cfg_idx_t CFG_LONGEST_DASH   = 3'd2;
  localparam cfg_idx_t CFG_LETTER_GAP     = 3'd3;
  localparam cfg_idx_t CFG_WORD_GAP       = 3'd4;
  localparam cfg_idx_t CFG_MESSAGE_GAP    = 3'd5;

  localparam time_t RST_DEBOUNCE_TIME  = 32'd50;
  localparam time_t RST_DOT_DASH_LIMIT = 32'd200;
  localparam time_t RST_LONGEST_DASH   = 32'd1000;
  localparam time_t RST_LETTER_GAP     = 32'd600;
  localparam time_t RST_WORD_GAP       = 32'd1400;
  localparam time_t RST_MESSAGE_GAP    = 32'd5000;

  typedef struct packed {
    time_t debounce_time;
    time_t dot_dash_limit;
    time_t longest_dash;
    time_t letter_gap;
    time_t word_gap;
    time_t message_gap;
  } cfg_t;

  typedef struct packed {
    logic  prev_raw_level;
    time_t debounce_start;
    logic  key_closed;
    time_t change_time;
    elem_t element_bits;
    cnt_t  element_count;
    logic  message_nonempty;
    logic  last_was_space;
  } state_t;

  typedef struct packed {
    logic led_on;
    logic letter_valid;
    pat_t letter_pattern;
    cnt_t letter_length;
    logic space_valid;
    logic message_end;
  } result_t;

endpackage

FILE: rtl/core/mkd_if.sv
// Request channel interfaces for the keyer timing decoder (tick in, result out).
// Depends on mkd_pkg.
interface mkd_in_if;
  logic            valid;
  logic            ready;
  mkd_pkg::time_t  now_time;
  logic            key_level;

  modport source (output valid, output now_time, output key_level, input ready);
  modport sink   (input valid, input now_time, input key_level, output ready);
endinterface

interface mkd_out_if;
  logic           valid;
  logic           ready;
  logic           led_on;
  logic           letter_valid;
  mkd_pkg::pat_t  letter_pattern;
  mkd_pkg::cnt_t  letter_length;
  logic           space_valid;
  logic           message_end;

  modport source (output valid, output led_on, output letter_valid, output letter_pattern,
                  output letter_length, output space_valid, output message_end,
                  input ready);
  modport sink   (input valid, input led_on, input letter_valid, input letter_pattern,
                  input letter_length, input space_valid, input message_end,
                  output ready);
endinterface

FILE: rtl/core/mkd_step.sv
// Per-tick decode logic: debounce, press classification, element gathering
// and gap flags. Purely combinational. Depends on mkd_pkg.
module mkd_step (
  input  mkd_pkg::cfg_t    cfg,
  input  mkd_pkg::state_t  st,
  input  mkd_pkg::time_t   now_time,
  input  logic             key_level,
  output mkd_pkg::state_t  st_nxt,
  output mkd_pkg::result_t res
);
  import mkd_pkg::*;

  time_t db_start;
  logic  settled;
  time_t ct_clip;
  time_t press_len;
  time_t open_len;
  logic  is_dot;
  logic  is_dash;
  elem_t bits_v;
  cnt_t  cnt_v;
  logic  letter;
  logic  nonempty_v;
  logic  lws_v;

  always_comb begin
    st_nxt = st;
    res    = '0;
    letter = 1'b0;

    db_start = (key_level != st.prev_raw_level) ? now_time : st.debounce_start;
    settled  = (now_time - db_start) > cfg.debounce_time;
    // change time ahead of now is treated as zero
    ct_clip   = (st.change_time > now_time) ? '0 : st.change_time;
    press_len = now_time - ct_clip;
    open_len  = st.key_closed ? '0 : press_len;
    is_dot    = press_len < cfg.dot_dash_limit;
    is_dash   = !is_dot && (press_len < cfg.longest_dash);

    bits_v     = st.element_bits;
    cnt_v      = st.element_count;
    nonempty_v = st.message_nonempty;
    lws_v      = st.last_was_space;

    st_nxt.debounce_start = db_start;
    st_nxt.prev_raw_level = key_level;

    if (settled) begin
      if (!key_level) begin
        if (st.key_closed) begin
          if (is_dot || is_dash) begin
            bits_v[st.element_count[IDX_W-1:0]] = is_dash;
            cnt_v = st.element_count + cnt_t'(1);
            if (cnt_v >= cnt_t'(MAX_ELEMENTS)) begin
              letter = 1'b1;
            end
          end
          st_nxt.change_time = now_time;
          st_nxt.key_closed  = 1'b0;
        end else begin
          st_nxt.change_time = ct_clip;
        end
        if (!letter && cnt_v != '0 && open_len >= cfg.letter_gap) begin
          letter = 1'b1;
        end
        if (letter) begin
          res.letter_valid   = 1'b1;
          res.letter_pattern = pat_t'(bits_v);
          res.letter_length  = cnt_v;
          nonempty_v = 1'b1;
          lws_v      = 1'b0;
          bits_v     = '0;
          cnt_v      = '0;
        end
        if (nonempty_v) begin
          if (open_len >= cfg.message_gap) begin
            res.message_end = 1'b1;
            nonempty_v = 1'b0;
            lws_v      = 1'b0;
          end else if (!lws_v && open_len >= cfg.word_gap) begin
            res.space_valid = 1'b1;
            lws_v = 1'b1;
          end
        end
      end else if (!st.key_closed) begin
        st_nxt.change_time = now_time;
        st_nxt.key_closed  = 1'b1;
      end
    end

    st_nxt.element_bits     = bits_v;
    st_nxt.element_count    = cnt_v;
    st_nxt.message_nonempty = nonempty_v;
    st_nxt.last_was_space   = lws_v;
    res.led_on              = st_nxt.key_closed;
  end

endmodule

FILE: rtl/core/morse_key_timing_decoder_top.sv
// Top level of the keyer timing decoder: input register, decode step,
// result register and configuration registers. Depends on mkd_pkg, mkd_if, mkd_step.
// A tick request accepted into the input register is decoded into the result register
// once that register is free or being taken. Throughput: one tick per cycle when
// results are taken; the input register refills while a result waits.
// Reset (rst_n, synchronous): decoder state cleared, registers to defaults,
// both pipeline stages empty.
module morse_key_timing_decoder_top (
  input  logic                 clk,
  input  logic                 rst_n,
  mkd_in_if.sink               in_chan,
  mkd_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  mkd_pkg::cfg_idx_t    cfg_index,
  input  mkd_pkg::cfg_data_t   cfg_wdata
);
  import mkd_pkg::*;

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    stg_valid_r;
  time_t   stg_now_r;
  logic    stg_key_r;
  logic    in_fire;
  logic    advance;

  assign advance       = stg_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !stg_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  mkd_step u_step (
    .cfg       (cfg_r),
    .st        (state_r),
    .now_time  (stg_now_r),
    .key_level (stg_key_r),
    .st_nxt    (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_time  <= RST_DEBOUNCE_TIME;
      cfg_r.dot_dash_limit <= RST_DOT_DASH_LIMIT;
      cfg_r.longest_dash   <= RST_LONGEST_DASH;
      cfg_r.letter_gap     <= RST_LETTER_GAP;
      cfg_r.word_gap       <= RST_WORD_GAP;
      cfg_r.message_gap    <= RST_MESSAGE_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE_TIME:  cfg_r.debounce_time  <= cfg_wdata;
        CFG_DOT_DASH_LIMIT: cfg_r.dot_dash_limit <= cfg_wdata;
        CFG_LONGEST_DASH:   cfg_r.longest_dash   <= cfg_wdata;
        CFG_LETTER_GAP:     cfg_r.letter_gap     <= cfg_wdata;
        CFG_WORD_GAP:       cfg_r.word_gap       <= cfg_wdata;
        CFG_MESSAGE_GAP:    cfg_r.message_gap    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_fire) begin
      stg_valid_r <= 1'b1;
    end else if (advance) begin
      stg_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_now_r <= in_chan.now_time;
      stg_key_r <= in_chan.key_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.led_on         = res_r.led_on;
  assign out_chan.letter_valid   = res_r.letter_valid;
  assign out_chan.letter_pattern = res_r.letter_pattern;
  assign out_chan.letter_length  = res_r.letter_length;
  assign out_chan.space_valid    = res_r.space_valid;
  assign out_chan.message_end    = res_r.message_end;

endmodule
